// ----- rtl/vwt_pkg.sv -----
package vwt_pkg;

   localparam int POS_W   = 24;
   localparam int NORM_W  = 16;
   localparam int TEX_W   = 16;
   localparam int CLIP_W  = 32;
   localparam int POINT_W = 16;
   localparam int PTOL_W  = 24;
   localparam int NTOL_W  = 15;
   localparam int IDX_W   = 8;

   // 0.005 in Q4.12 is 20.48 codes
   localparam int TEX_TOL_CODES = 20;

   localparam logic [1:0] CSR_POS_TOL    = 2'd0;
   localparam logic [1:0] CSR_NORM_TOL   = 2'd1;
   localparam logic [1:0] CSR_POINT_MATCH = 2'd2;

   localparam logic OP_SEARCH = 1'b0;
   localparam logic OP_APPEND = 1'b1;

   // one vertex as carried through the cells
   typedef struct packed {
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
      logic signed [NORM_W-1:0] norm_x;
      logic signed [NORM_W-1:0] norm_y;
      logic signed [NORM_W-1:0] norm_z;
      logic [CLIP_W-1:0]        clip;
      logic signed [TEX_W-1:0]  tex_u;
      logic signed [TEX_W-1:0]  tex_v;
      logic [POINT_W-1:0]       point;
   } vertex_type;

   typedef struct packed {
      logic [2*PTOL_W-1:0] ptol2;
      logic [2*NTOL_W-1:0] ntol2;
      logic                point_match;
   } tol_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

endpackage

// ----- rtl/vwt_cell.sv -----
// Compare stage: a stored entry walks through a short chain of these cells,
// each comparing it with the probe vertex, one partial result per cell per cycle.
module vwt_cell
   import vwt_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic       in_hit,
   input  logic [2*POS_W+1:0] in_acc,
   input  vertex_type in_entry,
   input  vertex_type in_probe,
   input  tol_type    tol,
   output logic       out_valid,
   output logic       out_hit,
   output logic [2*POS_W+1:0] out_acc
);

   logic valid_ff;
   logic hit_ff, hit_in;
   logic [2*POS_W+1:0] acc_ff, acc_in;
   logic signed [POS_W:0] dp;
   logic signed [NORM_W:0] dn;
   logic signed [TEX_W:0] du, dv;
   logic [POS_W:0] ap;
   logic [NORM_W:0] an;

   always_comb begin
      hit_in = in_hit;
      acc_in = in_acc;
      dp = '0;
      dn = '0;
      du = '0;
      dv = '0;
      ap = '0;
      an = '0;
      case (STAGE)
         0, 1, 2: begin
            if (STAGE == 0) begin
               dp = {in_entry.pos_x[POS_W-1], in_entry.pos_x}
                  - {in_probe.pos_x[POS_W-1], in_probe.pos_x};
               acc_in = '0;
               hit_in = (in_entry.clip == in_probe.clip)
                  && (!tol.point_match || in_entry.point == in_probe.point);
            end else if (STAGE == 1) begin
               dp = {in_entry.pos_y[POS_W-1], in_entry.pos_y}
                  - {in_probe.pos_y[POS_W-1], in_probe.pos_y};
            end else begin
               dp = {in_entry.pos_z[POS_W-1], in_entry.pos_z}
                  - {in_probe.pos_z[POS_W-1], in_probe.pos_z};
            end
            ap = dp[POS_W] ? POS_W'(0) - dp : dp;
            acc_in = (STAGE == 0 ? '0 : in_acc) + (2*POS_W+2)'(ap * ap);
         end
         3: begin
            hit_in = in_hit && ({2'b00, tol.ptol2} >= in_acc);
            dn = {in_entry.norm_x[NORM_W-1], in_entry.norm_x}
               - {in_probe.norm_x[NORM_W-1], in_probe.norm_x};
            an = dn[NORM_W] ? (NORM_W+1)'(0) - dn : dn;
            acc_in = (2*POS_W+2)'(an * an);
         end
         4, 5: begin
            if (STAGE == 4)
               dn = {in_entry.norm_y[NORM_W-1], in_entry.norm_y}
                  - {in_probe.norm_y[NORM_W-1], in_probe.norm_y};
            else
               dn = {in_entry.norm_z[NORM_W-1], in_entry.norm_z}
                  - {in_probe.norm_z[NORM_W-1], in_probe.norm_z};
            an = dn[NORM_W] ? (NORM_W+1)'(0) - dn : dn;
            acc_in = in_acc + (2*POS_W+2)'(an * an);
         end
         default: begin
            du = {in_entry.tex_u[TEX_W-1], in_entry.tex_u}
               - {in_probe.tex_u[TEX_W-1], in_probe.tex_u};
            dv = {in_entry.tex_v[TEX_W-1], in_entry.tex_v}
               - {in_probe.tex_v[TEX_W-1], in_probe.tex_v};
            hit_in = in_hit
               && ((2*POS_W+2)'(tol.ntol2) >= in_acc)
               && du <= (TEX_W+1)'(TEX_TOL_CODES) && du >= -(TEX_W+1)'(TEX_TOL_CODES)
               && dv <= (TEX_W+1)'(TEX_TOL_CODES) && dv >= -(TEX_W+1)'(TEX_TOL_CODES);
            acc_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      hit_ff <= hit_in;
      acc_ff <= acc_in;
   end

   assign out_valid = valid_ff;
   assign out_hit   = hit_ff;
   assign out_acc   = acc_ff;

endmodule

// ----- rtl/vertex_weld_table_unit.sv -----
// Vertex welding table. A request (start while not busy) takes one vertex.
// Search mode streams the stored entries from index 0 through a seven-cell
// compare chain, one entry per cycle, and the result follows once the last
// entry has left the chain and the drain count has run out; append mode and
// an empty table skip the stream. busy stays high through the result cycle,
// so the next request is taken in the cycle after the result.
// Each request gives exactly one result, shown for one cycle with
// rsp_valid; the receiver cannot stall it. The entry store is a memory read
// at one address per cycle and written once per stored entry (an append or
// a missed search, while not full); entries are never cleared, entry_count
// bounds the search. Write configuration only while the block is idle.
module vertex_weld_table_unit
   import vwt_pkg::*;
#(
   parameter int TABLE_DEPTH = 256,
   parameter int CLIP_BITS   = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_operation,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [POS_W-1:0]  req_pos_z,
   input  logic signed [NORM_W-1:0] req_norm_x,
   input  logic signed [NORM_W-1:0] req_norm_y,
   input  logic signed [NORM_W-1:0] req_norm_z,
   input  logic [CLIP_W-1:0]        req_clip_flags,
   input  logic signed [TEX_W-1:0]  req_tex_u,
   input  logic signed [TEX_W-1:0]  req_tex_v,
   input  logic [POINT_W-1:0]       req_point_index,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [PTOL_W-1:0]        csr_data,
   output logic                     rsp_valid,
   output logic [IDX_W-1:0]         rsp_vertex_index,
   output logic                     rsp_reused,
   output logic                     rsp_table_full
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int NCELL = 7;
   localparam logic [CLIP_W-1:0] CLIP_MASK = CLIP_W'((64'd1 << CLIP_BITS) - 64'd1);

   logic [PTOL_W-1:0] ptol_ff;
   logic [NTOL_W-1:0] ntol_ff;
   logic              pmatch_ff;
   tol_type           tol_ff;

   state_type state_ff, state_in;
   vertex_type probe_ff;
   logic op_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] out_idx_ff, out_idx_in;
   logic rd_valid_ff, rd_valid_in;
   logic found_ff, found_in;
   logic [AW-1:0] found_idx_ff, found_idx_in;
   logic [3:0] drain_ff, drain_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic rsp_reused_ff, rsp_reused_in;
   logic rsp_full_ff, rsp_full_in;
   logic mem_we;

   vertex_type mem [TABLE_DEPTH];
   vertex_type entry_ff;
   vertex_type entry_pipe [NCELL-1];
   vertex_type cell_entry [NCELL];
   logic       v_pipe [NCELL+1];
   logic       h_pipe [NCELL+1];
   logic [2*POS_W+1:0] a_pipe [NCELL+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         ptol_ff   <= '0;
         ntol_ff   <= '0;
         pmatch_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_POS_TOL:     ptol_ff   <= csr_data;
            CSR_NORM_TOL:    ntol_ff   <= csr_data[NTOL_W-1:0];
            CSR_POINT_MATCH: pmatch_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // squared tolerances, settled long before any request uses them
   always_ff @(posedge clock) begin
      tol_ff.ptol2       <= ptol_ff * ptol_ff;
      tol_ff.ntol2       <= ntol_ff * ntol_ff;
      tol_ff.point_match <= pmatch_ff;
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         op_ff          <= req_operation;
         probe_ff.pos_x  <= req_pos_x;
         probe_ff.pos_y  <= req_pos_y;
         probe_ff.pos_z  <= req_pos_z;
         probe_ff.norm_x <= req_norm_x;
         probe_ff.norm_y <= req_norm_y;
         probe_ff.norm_z <= req_norm_z;
         probe_ff.clip   <= req_clip_flags & CLIP_MASK;
         probe_ff.tex_u  <= req_tex_u;
         probe_ff.tex_v  <= req_tex_v;
         probe_ff.point  <= req_point_index;
      end
   end

   assign mem_we = (state_ff == ST_DRAIN) && (drain_ff == 4'd0) && !found_ff
      && (count_ff != CW'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[count_ff[AW-1:0]] <= probe_ff;
      entry_ff <= mem[rd_ptr_ff[AW-1:0]];
   end

   assign v_pipe[0] = rd_valid_ff;
   assign h_pipe[0] = 1'b0;
   assign a_pipe[0] = '0;
   assign cell_entry[0] = entry_ff;

   // entry copies that follow the chain; out_idx_ff counts the entries leaving the last cell
   always_ff @(posedge clock) begin
      entry_pipe[0] <= entry_ff;
   end

   genvar g;
   generate
      for (g = 0; g < NCELL; g++) begin : g_cell
         if (g > 0) begin : g_tap
            assign cell_entry[g] = entry_pipe[g-1];
         end
         if (g > 0 && g < NCELL - 1) begin : g_ent
            always_ff @(posedge clock) entry_pipe[g] <= entry_pipe[g-1];
         end
         vwt_cell #(.STAGE(g)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (v_pipe[g]),
            .in_hit    (h_pipe[g]),
            .in_acc    (a_pipe[g]),
            .in_entry  (cell_entry[g]),
            .in_probe  (probe_ff),
            .tol       (tol_ff),
            .out_valid (v_pipe[g+1]),
            .out_hit   (h_pipe[g+1]),
            .out_acc   (a_pipe[g+1])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ptr_ff     <= rd_ptr_in;
      out_idx_ff    <= out_idx_in;
      found_idx_ff  <= found_idx_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_reused_ff <= rsp_reused_in;
      rsp_full_ff   <= rsp_full_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      rd_valid_in   = 1'b0;
      out_idx_in    = out_idx_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      drain_in      = drain_ff;
      rsp_valid_in  = 1'b0;
      rsp_idx_in    = rsp_idx_ff;
      rsp_reused_in = rsp_reused_ff;
      rsp_full_in   = rsp_full_ff;
      // record the first hit leaving the chain
      if (v_pipe[NCELL]) begin
         if (h_pipe[NCELL] && !found_ff) begin
            found_in     = 1'b1;
            found_idx_in = out_idx_ff[AW-1:0];
         end
         out_idx_in = out_idx_ff + CW'(1);
      end
      case (state_ff)
         ST_IDLE: begin
            if (start && !busy) begin
               rd_ptr_in  = '0;
               out_idx_in = '0;
               found_in   = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (op_ff == OP_SEARCH && rd_ptr_ff != count_ff) begin
               rd_valid_in = 1'b1;
               rd_ptr_in   = rd_ptr_ff + CW'(1);
            end else begin
               drain_in = 4'(NCELL + 3);
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_ff != 4'd0) begin
               drain_in = drain_ff - 4'd1;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (found_ff) begin
                  rsp_idx_in    = IDX_W'(found_idx_ff);
                  rsp_reused_in = 1'b1;
                  rsp_full_in   = 1'b0;
               end else if (count_ff == CW'(TABLE_DEPTH)) begin
                  rsp_idx_in    = '0;
                  rsp_reused_in = 1'b0;
                  rsp_full_in   = 1'b1;
               end else begin
                  rsp_idx_in    = IDX_W'(count_ff);
                  rsp_reused_in = 1'b0;
                  rsp_full_in   = 1'b0;
                  count_in      = count_ff + CW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy             = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_idx_ff;
   assign rsp_reused       = rsp_reused_ff;
   assign rsp_table_full   = rsp_full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count past depth");
   a_rsp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_reused && rsp_table_full))
      else $error("reused and full together");
   a_rsp_from_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DRAIN))
      else $error("result outside drain");
   a_no_scan_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !rd_valid_ff)
      else $error("read issued while idle");

endmodule

// ----- sim/tb.sv -----
module tb;
   import vwt_pkg::*;

   typedef struct {
      logic [IDX_W-1:0] index;
      logic             reused;
      logic             full;
   } weld_result_type;

   class weld_scoreboard;
      logic [PTOL_W-1:0] pos_tol;
      logic [NTOL_W-1:0] norm_tol;
      logic              point_match;
      vertex_type        entries[256];
      int                entry_count;
      weld_result_type   expected_q[$];
      int                errors;
      int                checked;
      int                reuse_seen;
      int                full_seen;

      function new();
         pos_tol = '0;
         norm_tol = '0;
         point_match = 1'b0;
         entry_count = 0;
         errors = 0;
         checked = 0;
         reuse_seen = 0;
         full_seen = 0;
      endfunction

      function void write_csr(logic [1:0] index, logic [PTOL_W-1:0] data);
         case (index)
            CSR_POS_TOL: pos_tol = data;
            CSR_NORM_TOL: norm_tol = data[NTOL_W-1:0];
            CSR_POINT_MATCH: point_match = data[0];
            default: ;
         endcase
      endfunction

      function longint sq_dist(int a, int b);
         longint d;
         d = longint'(a) - longint'(b);
         return d * d;
      endfunction

      function bit tex_close(int a, int b);
         int d;
         d = a - b;
         if (d < 0) d = -d;
         return d <= TEX_TOL_CODES;
      endfunction

      function bit entry_matches(vertex_type e, vertex_type v);
         longint d;
         longint ptol2;
         longint ntol2;
         ptol2 = longint'(pos_tol) * longint'(pos_tol);
         ntol2 = longint'(norm_tol) * longint'(norm_tol);
         if (point_match && e.point != v.point) return 0;
         if (e.clip != v.clip) return 0;
         d = sq_dist($signed(e.pos_x), $signed(v.pos_x)) + sq_dist($signed(e.pos_y), $signed(v.pos_y))
           + sq_dist($signed(e.pos_z), $signed(v.pos_z));
         if (d > ptol2) return 0;
         d = sq_dist($signed(e.norm_x), $signed(v.norm_x))
           + sq_dist($signed(e.norm_y), $signed(v.norm_y))
           + sq_dist($signed(e.norm_z), $signed(v.norm_z));
         if (d > ntol2) return 0;
         if (!tex_close($signed(e.tex_u), $signed(v.tex_u))) return 0;
         if (!tex_close($signed(e.tex_v), $signed(v.tex_v))) return 0;
         return 1;
      endfunction

      function void note_vertex(logic op, vertex_type v);
         weld_result_type r;
         if (op == OP_SEARCH) begin
            for (int i = 0; i < entry_count; i++) begin
               if (entry_matches(entries[i], v)) begin
                  r.index = i[IDX_W-1:0];
                  r.reused = 1'b1;
                  r.full = 1'b0;
                  expected_q.push_back(r);
                  return;
               end
            end
         end
         if (entry_count >= 256) begin
            r.index = '0;
            r.reused = 1'b0;
            r.full = 1'b1;
         end else begin
            entries[entry_count] = v;
            r.index = entry_count[IDX_W-1:0];
            r.reused = 1'b0;
            r.full = 1'b0;
            entry_count++;
         end
         expected_q.push_back(r);
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_result(logic [IDX_W-1:0] index, logic reused, logic full);
         weld_result_type e;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result index %0d", index));
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (reused) reuse_seen++;
         if (full) full_seen++;
         if (index !== e.index)
            report($sformatf("vertex_index %0d, want %0d", index, e.index));
         if (reused !== e.reused)
            report($sformatf("reused %0b, want %0b", reused, e.reused));
         if (full !== e.full)
            report($sformatf("table_full %0b, want %0b", full, e.full));
      endtask
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic req_operation;
   logic signed [POS_W-1:0] req_pos_x, req_pos_y, req_pos_z;
   logic signed [NORM_W-1:0] req_norm_x, req_norm_y, req_norm_z;
   logic [CLIP_W-1:0] req_clip_flags;
   logic signed [TEX_W-1:0] req_tex_u, req_tex_v;
   logic [POINT_W-1:0] req_point_index;
   logic csr_write;
   logic [1:0] csr_index;
   logic [PTOL_W-1:0] csr_data;
   logic rsp_valid;
   logic [IDX_W-1:0] rsp_vertex_index;
   logic rsp_reused;
   logic rsp_table_full;

   weld_scoreboard sb;

   vertex_weld_table_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_norm_x(req_norm_x), .req_norm_y(req_norm_y), .req_norm_z(req_norm_z),
      .req_clip_flags(req_clip_flags), .req_tex_u(req_tex_u), .req_tex_v(req_tex_v),
      .req_point_index(req_point_index),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_vertex_index(rsp_vertex_index),
      .rsp_reused(rsp_reused), .rsp_table_full(rsp_table_full)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("vertex_weld_table_unit test failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_vertex_index, rsp_reused, rsp_table_full);
   end

   task send_vertex(input logic op, input vertex_type v, input int gap);
      @(negedge clock);
      start <= 1'b1;
      req_operation <= op;
      req_pos_x <= v.pos_x;
      req_pos_y <= v.pos_y;
      req_pos_z <= v.pos_z;
      req_norm_x <= v.norm_x;
      req_norm_y <= v.norm_y;
      req_norm_z <= v.norm_z;
      req_clip_flags <= v.clip;
      req_tex_u <= v.tex_u;
      req_tex_v <= v.tex_v;
      req_point_index <= v.point;
      // busy read here is the value seen by the edge
      do @(posedge clock); while (busy);
      sb.note_vertex(op, v);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task drain;
      @(negedge clock);
      start <= 1'b0;
      while (sb.expected_q.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_csr(input logic [1:0] index, input logic [PTOL_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      sb.write_csr(index, data);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic vertex_type rand_vertex();
      vertex_type v;
      v.pos_x = POS_W'($urandom);
      v.pos_y = POS_W'($urandom);
      v.pos_z = POS_W'($urandom);
      v.norm_x = NORM_W'($urandom);
      v.norm_y = NORM_W'($urandom);
      v.norm_z = NORM_W'($urandom);
      v.clip = $urandom;
      v.tex_u = TEX_W'($urandom);
      v.tex_v = TEX_W'($urandom);
      v.point = POINT_W'($urandom);
      return v;
   endfunction

   function automatic int jitter(int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   // move a stored vertex around the tolerance boundary
   function automatic vertex_type near_vertex(vertex_type e);
      vertex_type v;
      int ps;
      int ns;
      v = e;
      ps = int'(sb.pos_tol) / 2 + 2;
      ns = int'(sb.norm_tol) / 2 + 2;
      if ($urandom_range(0, 3) != 0) begin
         v.pos_x = POS_W'($signed(e.pos_x) + jitter(ps));
         v.pos_y = POS_W'($signed(e.pos_y) + jitter(ps));
         v.pos_z = POS_W'($signed(e.pos_z) + jitter(ps));
         v.norm_x = NORM_W'($signed(e.norm_x) + jitter(ns));
         v.norm_y = NORM_W'($signed(e.norm_y) + jitter(ns));
         v.norm_z = NORM_W'($signed(e.norm_z) + jitter(ns));
         v.tex_u = TEX_W'($signed(e.tex_u) + jitter(22));
         v.tex_v = TEX_W'($signed(e.tex_v) + jitter(22));
      end
      if ($urandom_range(0, 9) == 0) v.clip[$urandom_range(0, CLIP_W-1)] ^= 1'b1;
      if ($urandom_range(0, 5) == 0) v.point = POINT_W'($urandom);
      return v;
   endfunction

   function automatic int pick_gap(int pct);
      if ($urandom_range(0, 99) < pct) return $urandom_range(1, 6);
      return 0;
   endfunction

   vertex_type vmax, vmin, vt;
   int idle_pct;
   int n_items;

   initial begin
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_SEARCH;
      req_pos_x = '0; req_pos_y = '0; req_pos_z = '0;
      req_norm_x = '0; req_norm_y = '0; req_norm_z = '0;
      req_clip_flags = '0; req_tex_u = '0; req_tex_v = '0; req_point_index = '0;
      csr_write = 1'b0;
      csr_index = CSR_POS_TOL;
      csr_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      vmax = '{pos_x: 24'sh7fffff, pos_y: 24'sh7fffff, pos_z: 24'sh7fffff,
               norm_x: 16'sh7fff, norm_y: 16'sh7fff, norm_z: 16'sh7fff,
               clip: 32'hffffffff, tex_u: 16'sh7fff, tex_v: 16'sh7fff, point: 16'hffff};
      vmin = '{pos_x: 24'sh800000, pos_y: 24'sh800000, pos_z: 24'sh800000,
               norm_x: 16'sh8000, norm_y: 16'sh8000, norm_z: 16'sh8000,
               clip: 32'h0, tex_u: 16'sh8000, tex_v: 16'sh8000, point: 16'h0};

      // directed: empty table, exact hits, texture edge, clip mismatch, append
      send_vertex(OP_SEARCH, vmax, 1);
      send_vertex(OP_APPEND, vmin, 0);
      send_vertex(OP_SEARCH, vmax, 0);
      send_vertex(OP_SEARCH, vmin, 2);
      vt = vmin; vt.tex_u = vmin.tex_u + TEX_W'(20);
      send_vertex(OP_SEARCH, vt, 0);
      vt = vmin; vt.tex_v = vmin.tex_v + TEX_W'(21);
      send_vertex(OP_SEARCH, vt, 0);
      vt = vmax; vt.clip[0] = 1'b0;
      send_vertex(OP_SEARCH, vt, 1);
      send_vertex(OP_APPEND, vmax, 0);
      drain();
      write_csr(CSR_POS_TOL, 24'd4096);
      write_csr(CSR_NORM_TOL, 24'd100);
      write_csr(CSR_POINT_MATCH, 24'd1);
      write_csr(2'd3, 24'hffffff);
      vt = vmin; vt.pos_x = vmin.pos_x + POS_W'(4096);
      send_vertex(OP_SEARCH, vt, 0);
      vt = vmin; vt.pos_x = vmin.pos_x + POS_W'(2896); vt.pos_y = vmin.pos_y + POS_W'(2897);
      send_vertex(OP_SEARCH, vt, 0);
      vt = vmin; vt.point = 16'h0001;
      send_vertex(OP_SEARCH, vt, 0);
      vt = vmin; vt.norm_x = vmin.norm_x + NORM_W'(100); vt.norm_y = vmin.norm_y + NORM_W'(1);
      send_vertex(OP_SEARCH, vt, 0);
      vt = vmax; vt.pos_z = vmax.pos_z - POS_W'(4097);
      send_vertex(OP_SEARCH, vt, 0);
      drain();

      n_items = 0;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin write_csr(CSR_POS_TOL, 24'd0); write_csr(CSR_NORM_TOL, 24'd0);
                  write_csr(CSR_POINT_MATCH, 24'd0); end
            1: begin write_csr(CSR_POS_TOL, 24'hffffff); write_csr(CSR_NORM_TOL, 24'h7fff);
                  write_csr(CSR_POINT_MATCH, 24'd1); end
            default: begin
               write_csr(CSR_POS_TOL, PTOL_W'($urandom_range(0, 20000)));
               write_csr(CSR_NORM_TOL, PTOL_W'($urandom_range(0, 3000)));
               write_csr(CSR_POINT_MATCH, PTOL_W'($urandom_range(0, 1)));
            end
         endcase
         case (phase % 4)
            0: idle_pct = 0;
            1: idle_pct = 70;
            2: idle_pct = 20;
            default: idle_pct = 70;
         endcase
         for (int k = 0; k < 238; k++) begin
            if (sb.entry_count > 0 && $urandom_range(0, 99) < 55)
               vt = near_vertex(sb.entries[$urandom_range(0, sb.entry_count - 1)]);
            else
               vt = rand_vertex();
            send_vertex(($urandom_range(0, 99) < 10) ? OP_APPEND : OP_SEARCH, vt,
                        pick_gap(idle_pct));
            n_items++;
         end
         drain();
      end

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("covered %0d random vertices over 8 tolerance settings, %0d results checked",
               n_items, sb.checked);
      $display("welds %0d, full-table answers %0d, stored entries %0d",
               sb.reuse_seen, sb.full_seen, sb.entry_count);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("vertex_weld_table_unit test passed");
      end else begin
         $display("vertex_weld_table_unit test failed");
      end
      $finish;
   end

endmodule
